// ===== src/adbm_pkg.sv =====
// Shared types, constants and register codes of the ADC board-id and battery monitor.
package adbm_pkg;

  localparam int MV_W    = 16;
  localparam int CONV_W  = 24;
  localparam int VER_W   = 8;
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 16;
  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;
  localparam logic CH_VERSION = 1'b0;
  localparam logic CH_BATTERY = 1'b1;

  localparam logic [3:0]  RST_SAMPLES     = 4'd5;
  localparam logic [3:0]  RST_RANGE_COUNT = 4'd4;
  localparam logic [15:0] RST_DIV_RATIO   = 16'd0;
  localparam logic [15:0] RST_LOW_ADC     = 16'd1422;
  localparam logic [15:0] RST_LOW_BATT    = 16'd7000;
  localparam logic [15:0] RST_HIGH_ADC    = 16'd1707;
  localparam logic [15:0] RST_HIGH_BATT   = 16'd8400;

  localparam logic [15:0] RATIO_SCALE  = 16'd1000;
  localparam logic [15:0] FALLBACK_MUL = 16'd8400;
  localparam logic [15:0] FALLBACK_DIV = 16'd1800;
  localparam logic [CONV_W-1:0] SAT_MAX = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES     = 3'd0,
    REG_RANGE_COUNT = 3'd1,
    REG_DIV_RATIO   = 3'd2,
    REG_LOW_ADC     = 3'd3,
    REG_LOW_BATT    = 3'd4,
    REG_HIGH_ADC    = 3'd5,
    REG_HIGH_BATT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [VER_W-1:0] version;
    logic [MV_W-1:0]  max_mv;
    logic [MV_W-1:0]  min_mv;
  } range_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_CONV_PREP,
    ST_CONV_START,
    ST_CONV_WAIT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_sel_conv;
    logic avg_load;
    logic conv_prep;
    logic conv_load;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic complete;
    logic div_done;
    logic batt;
    logic need_div;
    logic scan_done;
    logic out_busy;
  } dp_status_t;

  function automatic range_entry_t default_range(input int idx);
    range_entry_t e;
    e = '0;
    case (idx)
      0: begin
        e.min_mv = 16'd0;    e.max_mv = 16'd200;  e.version = 8'd0;
      end
      1: begin
        e.min_mv = 16'd1600; e.max_mv = 16'd2000; e.version = 8'd1;
      end
      2: begin
        e.min_mv = 16'd800;  e.max_mv = 16'd1000; e.version = 8'd2;
      end
      3: begin
        e.min_mv = 16'd250;  e.max_mv = 16'd350;  e.version = 8'd3;
      end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// ===== src/adbm_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the mean and the conversion.
module adbm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [adbm_pkg::DIV_W-1:0]    dividend,
  input  logic [adbm_pkg::DVS_W-1:0]    divisor,
  output logic                          done,
  output logic [adbm_pkg::DIV_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(adbm_pkg::DIV_W);

  logic                         busy;
  logic [CNT_W-1:0]             cnt;
  logic [adbm_pkg::DIV_W-1:0]   q;
  logic [adbm_pkg::DVS_W-1:0]   rem;
  logic [adbm_pkg::DVS_W:0]     trial;
  logic                         ge;
  logic [adbm_pkg::DVS_W-1:0]   rem_next;

  always_comb begin
    trial    = {rem, q[adbm_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? adbm_pkg::DVS_W'(trial - {1'b0, divisor})
                  : trial[adbm_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= dividend;
        rem  <= '0;
      end else if (busy) begin
        q   <= {q[adbm_pkg::DIV_W-2:0], ge};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(adbm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

// ===== src/adbm_datapath.sv =====
// Datapath: registers, accumulators, range table, conversion and the output word register.
module adbm_datapath #(
  parameter int RANGE_ENTRIES = 10,
  parameter int MAX_SAMPLES   = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [adbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adbm_pkg::CFG_W-1:0]         cfg_data,
  input  logic [adbm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [adbm_pkg::IN_USER_W-1:0]     in_tuser,
  input  adbm_pkg::ctrl_cmd_t                cmd,
  output adbm_pkg::dp_status_t               stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [adbm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [adbm_pkg::OUT_USER_W-1:0]    out_tuser
);

  localparam int SUM_W  = $clog2(MAX_SAMPLES * 65535 + 1);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
  localparam int SCAN_W = $clog2(RANGE_ENTRIES + 1);

  // Configuration registers.
  logic [3:0]  samples_per_average;
  logic [3:0]  range_count;
  logic [15:0] divider_ratio_milli;
  logic [15:0] cal_low_adc_mv;
  logic [15:0] cal_low_batt_mv;
  logic [15:0] cal_high_adc_mv;
  logic [15:0] cal_high_batt_mv;

  // Input word fields.
  logic        action;
  logic        channel;
  logic [15:0] sample_mv;
  logic [3:0]  entry_index;
  adbm_pkg::range_entry_t entry_in;

  assign action            = in_tuser[0];
  assign channel           = in_tuser[1];
  assign sample_mv         = in_tdata[15:0];
  assign entry_index       = in_tdata[19:16];
  assign entry_in.min_mv   = in_tdata[35:20];
  assign entry_in.max_mv   = in_tdata[51:36];
  assign entry_in.version  = in_tdata[59:52];

  logic [SUM_W-1:0] sums   [2];
  logic [CNT_W-1:0] counts [2];
  adbm_pkg::range_entry_t tbl [RANGE_ENTRIES];

  // Working registers of the item in flight.
  logic                       ch_r;
  logic [SUM_W-1:0]           sum_w;
  logic [CNT_W-1:0]           cnt_w;
  logic [15:0]                avg;
  logic [31:0]                prod;
  logic [15:0]                dvs;
  logic [15:0]                base;
  logic                       need_div;
  logic [adbm_pkg::CONV_W-1:0] conv;
  logic                       matched;
  logic [SCAN_W-1:0]          scan_cnt;

  logic [15:0]                o_avg;
  logic [adbm_pkg::CONV_W-1:0] o_conv;
  logic                       o_match;
  logic                       o_ch;
  logic                       o_valid;

  // Sample accumulation.
  logic [7:0]       eff_samples;
  logic [SUM_W-1:0] next_sum;
  logic [CNT_W-1:0] next_cnt;
  logic             complete;

  always_comb begin
    if (samples_per_average == 4'd0) begin
      eff_samples = 8'd1;
    end else if ({4'b0, samples_per_average} > 8'(MAX_SAMPLES)) begin
      eff_samples = 8'(MAX_SAMPLES);
    end else begin
      eff_samples = {4'b0, samples_per_average};
    end
    next_sum = sums[channel] + SUM_W'(sample_mv);
    next_cnt = counts[channel] + 1'b1;
    complete = (action == adbm_pkg::ACT_SAMPLE) && (8'(next_cnt) >= eff_samples);
  end

  // Shared divider.
  logic                        div_done;
  logic [adbm_pkg::DIV_W-1:0]  quotient;
  logic [adbm_pkg::DIV_W-1:0]  div_dividend;
  logic [adbm_pkg::DVS_W-1:0]  div_divisor;

  assign div_dividend = cmd.div_sel_conv ? prod : adbm_pkg::DIV_W'(sum_w);
  assign div_divisor  = cmd.div_sel_conv ? dvs  : adbm_pkg::DVS_W'(cnt_w);

  adbm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Battery conversion setup: one multiply, registered before the divide.
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;
  logic [15:0] prep_div;
  logic [15:0] prep_base;
  logic        prep_need;

  always_comb begin
    mul_a     = avg;
    mul_b     = divider_ratio_milli;
    prep_div  = adbm_pkg::RATIO_SCALE;
    prep_base = 16'd0;
    prep_need = 1'b1;
    if (divider_ratio_milli != 16'd0) begin
      mul_b = divider_ratio_milli;
    end else if (cal_low_adc_mv != 16'd0 && cal_high_adc_mv != 16'd0) begin
      prep_base = cal_low_batt_mv;
      if (avg <= cal_low_adc_mv) begin
        prep_need = 1'b0;
      end else if (avg >= cal_high_adc_mv) begin
        prep_need = 1'b0;
        prep_base = cal_high_batt_mv;
      end else begin
        mul_a    = avg - cal_low_adc_mv;
        mul_b    = (cal_high_batt_mv > cal_low_batt_mv)
                   ? (cal_high_batt_mv - cal_low_batt_mv) : 16'd0;
        prep_div = cal_high_adc_mv - cal_low_adc_mv;
      end
    end else begin
      mul_b    = adbm_pkg::FALLBACK_MUL;
      prep_div = adbm_pkg::FALLBACK_DIV;
    end
  end

  assign product = {16'b0, mul_a} * {16'b0, mul_b};

  logic [32:0] conv_sum;
  assign conv_sum = {17'b0, base} + {1'b0, quotient};

  // Range table scan, one entry per cycle.
  logic [4:0]             scan_limit;
  logic                   scan_end;
  logic                   scan_hit;
  adbm_pkg::range_entry_t scan_entry;

  always_comb begin
    scan_limit = ({1'b0, range_count} > 5'(RANGE_ENTRIES)) ? 5'(RANGE_ENTRIES)
                                                           : {1'b0, range_count};
    scan_end   = 5'(scan_cnt) >= scan_limit;
    scan_entry = tbl[scan_cnt[IDX_W-1:0]];
    scan_hit   = !scan_end && (avg >= scan_entry.min_mv) && (avg <= scan_entry.max_mv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_average <= adbm_pkg::RST_SAMPLES;
      range_count         <= adbm_pkg::RST_RANGE_COUNT;
      divider_ratio_milli <= adbm_pkg::RST_DIV_RATIO;
      cal_low_adc_mv      <= adbm_pkg::RST_LOW_ADC;
      cal_low_batt_mv     <= adbm_pkg::RST_LOW_BATT;
      cal_high_adc_mv     <= adbm_pkg::RST_HIGH_ADC;
      cal_high_batt_mv    <= adbm_pkg::RST_HIGH_BATT;
    end else if (cfg_we) begin
      case (cfg_index)
        adbm_pkg::REG_SAMPLES:     samples_per_average <= cfg_data[3:0];
        adbm_pkg::REG_RANGE_COUNT: range_count         <= cfg_data[3:0];
        adbm_pkg::REG_DIV_RATIO:   divider_ratio_milli <= cfg_data;
        adbm_pkg::REG_LOW_ADC:     cal_low_adc_mv      <= cfg_data;
        adbm_pkg::REG_LOW_BATT:    cal_low_batt_mv     <= cfg_data;
        adbm_pkg::REG_HIGH_ADC:    cal_high_adc_mv     <= cfg_data;
        adbm_pkg::REG_HIGH_BATT:   cal_high_batt_mv    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
      for (int i = 0; i < RANGE_ENTRIES; i++) begin
        tbl[i] <= adbm_pkg::default_range(i);
      end
    end else if (cmd.take) begin
      if (action == adbm_pkg::ACT_LOAD) begin
        if ({1'b0, entry_index} < 5'(RANGE_ENTRIES)) begin
          tbl[entry_index[IDX_W-1:0]] <= entry_in;
        end
      end else if (complete) begin
        sums[channel]   <= '0;
        counts[channel] <= '0;
      end else begin
        sums[channel]   <= next_sum;
        counts[channel] <= next_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && complete) begin
      sum_w <= next_sum;
      cnt_w <= next_cnt;
      ch_r  <= channel;
    end
    if (cmd.avg_load) begin
      avg      <= quotient[15:0];
      scan_cnt <= '0;
      matched  <= 1'b0;
      conv     <= '0;
    end
    if (cmd.conv_prep) begin
      prod     <= product;
      dvs      <= prep_div;
      base     <= prep_base;
      need_div <= prep_need;
      conv     <= adbm_pkg::CONV_W'(prep_base);
      matched  <= 1'b1;
    end
    if (cmd.conv_load) begin
      conv <= (conv_sum > 33'(adbm_pkg::SAT_MAX)) ? adbm_pkg::SAT_MAX
                                                  : conv_sum[adbm_pkg::CONV_W-1:0];
    end
    if (cmd.scan_step) begin
      if (scan_hit) begin
        conv    <= adbm_pkg::CONV_W'(scan_entry.version);
        matched <= 1'b1;
      end else begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
    if (cmd.out_load) begin
      o_avg   <= avg;
      o_conv  <= conv;
      o_match <= matched;
      o_ch    <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.out_load) begin
      o_valid <= 1'b1;
    end else if (out_tready) begin
      o_valid <= 1'b0;
    end
  end

  assign stat.complete  = complete;
  assign stat.div_done  = div_done;
  assign stat.batt      = (ch_r == adbm_pkg::CH_BATTERY);
  assign stat.need_div  = need_div;
  assign stat.scan_done = scan_hit || scan_end;
  assign stat.out_busy  = o_valid && !out_tready;

  assign out_tvalid = o_valid;
  assign out_tdata  = {7'b0, o_match, o_conv, o_avg};
  assign out_tuser  = o_ch;

endmodule

// ===== src/adbm_ctrl.sv =====
// Controller state machine sequencing accept, mean, conversion or table scan, and output.
module adbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  adbm_pkg::dp_status_t stat,
  output adbm_pkg::ctrl_cmd_t  cmd
);

  adbm_pkg::state_t state;
  adbm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adbm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      adbm_pkg::ST_IDLE: begin
        if (in_tvalid && stat.complete) state_next = adbm_pkg::ST_AVG_START;
      end
      adbm_pkg::ST_AVG_START: state_next = adbm_pkg::ST_AVG_WAIT;
      adbm_pkg::ST_AVG_WAIT: begin
        if (stat.div_done) begin
          state_next = stat.batt ? adbm_pkg::ST_CONV_PREP : adbm_pkg::ST_SCAN;
        end
      end
      adbm_pkg::ST_CONV_PREP: state_next = adbm_pkg::ST_CONV_START;
      adbm_pkg::ST_CONV_START: begin
        state_next = stat.need_div ? adbm_pkg::ST_CONV_WAIT : adbm_pkg::ST_DONE;
      end
      adbm_pkg::ST_CONV_WAIT: begin
        if (stat.div_done) state_next = adbm_pkg::ST_DONE;
      end
      adbm_pkg::ST_SCAN: begin
        if (stat.scan_done) state_next = adbm_pkg::ST_DONE;
      end
      adbm_pkg::ST_DONE: begin
        if (!stat.out_busy) state_next = adbm_pkg::ST_IDLE;
      end
      default: state_next = adbm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state)
      adbm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      adbm_pkg::ST_AVG_START: cmd.div_start = 1'b1;
      adbm_pkg::ST_AVG_WAIT:  cmd.avg_load  = stat.div_done;
      adbm_pkg::ST_CONV_PREP: cmd.conv_prep = 1'b1;
      adbm_pkg::ST_CONV_START: begin
        cmd.div_start    = stat.need_div;
        cmd.div_sel_conv = 1'b1;
      end
      adbm_pkg::ST_CONV_WAIT: begin
        cmd.div_sel_conv = 1'b1;
        cmd.conv_load    = stat.div_done;
      end
      adbm_pkg::ST_SCAN: cmd.scan_step = 1'b1;
      adbm_pkg::ST_DONE: cmd.out_load  = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== src/adc_board_id_and_battery_monitor.sv =====
// Top level of the ADC board-id and battery monitor.
//
// Input words arrive on s_axis. A sample word (tuser action bit low) adds its
// millivolt reading to the running sum of its channel; once the channel holds
// samples_per_average readings, the mean is formed and one result word leaves
// on m_axis. A load word (action bit high) writes one range table entry and
// never produces a result; an index past the table writes nothing.
// Version results scan the range table one entry per cycle, first match wins.
// Battery results go through ratio, two-point or fallback conversion.
// From the accepted completing sample, the mean takes one pass through the
// shared 32-step bit-serial divider. The version channel then scans the
// table entry by entry; the battery channel registers its multiply and takes
// a second divider pass, skipped when the mean is clamped to a calibration
// point. Other samples are taken back to back. One average is in flight at a
// time; the next word is accepted as soon as the result sits in the output
// register, even if the receiver has not taken it yet. If the receiver stalls
// with a result still pending, the block waits before loading the next result.
// The configuration channel is always ready and should be written only when
// the block is idle. Reset restores the register defaults, clears both
// accumulators, restores the four default ranges and empties the output.
module adc_board_id_and_battery_monitor #(
  parameter int RANGE_ENTRIES = 10,
  parameter int MAX_SAMPLES   = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adbm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: sample_mv[15:0], entry_index[19:16], entry_min_mv[35:20],
  // entry_max_mv[51:36], entry_version[59:52], zero pad [63:60].
  input  logic [adbm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: action[0], channel[1].
  input  logic [adbm_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: average_mv[15:0], converted_value[39:16],
  // range_matched[40], zero pad [47:41].
  output logic [adbm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: result_channel[0].
  output logic [adbm_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

  adbm_pkg::ctrl_cmd_t  cmd;
  adbm_pkg::dp_status_t stat;

  // Register writes are always taken in the cycle they are offered.
  assign cfg_ready = 1'b1;

  adbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  adbm_datapath #(
    .RANGE_ENTRIES (RANGE_ENTRIES),
    .MAX_SAMPLES   (MAX_SAMPLES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (s_axis_tdata),
    .in_tuser   (s_axis_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_tdata  (m_axis_tdata),
    .out_tuser  (m_axis_tuser)
  );

endmodule

// ===== src/adbm_checker.sv =====
// Port-level checks of the monitor and the bind that attaches them to the top level.
module adbm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [adbm_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [adbm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word present after reset");

  // A load word never stalls the input side.
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == adbm_pkg::ACT_LOAD)
    |=> s_axis_tready)
    else $error("input stalled after a load word");

  // A fresh result only appears after the input side was held off.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result word appeared while input was open");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

endmodule

bind adc_board_id_and_battery_monitor adbm_checker u_adbm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the ADC board-id and battery monitor.
module testbench;

  localparam int TABLE_DEPTH     = 10;
  localparam int SAMPLE_LIMIT    = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 128;
  // Worst case is a battery average with two divider passes, which ends
  // well inside this settling time.
  localparam int SETTLE_CYCLES   = 150;
  localparam int LONG_HOLD       = 400;
  localparam int CYCLE_LIMIT     = 1000000;

  // One input word, unpacked.
  typedef struct {
    logic        action;
    logic        channel;
    logic [15:0] sample_mv;
    logic [3:0]  entry_index;
    logic [15:0] entry_min_mv;
    logic [15:0] entry_max_mv;
    logic [7:0]  entry_version;
  } adc_word_t;

  // One completed average as it should leave the block.
  typedef struct {
    logic        channel;
    logic [15:0] average_mv;
    logic [23:0] converted;
    logic        matched;
  } reading_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [adbm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [adbm_pkg::CFG_W-1:0]      cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [adbm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [adbm_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [adbm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [adbm_pkg::OUT_USER_W-1:0] m_axis_tuser;

  adc_board_id_and_battery_monitor #(
    .RANGE_ENTRIES(TABLE_DEPTH),
    .MAX_SAMPLES  (SAMPLE_LIMIT)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the register file, the accumulators and the range table.
  // Registers follow set_reg; the rest changes only when a word is accepted.
  logic [3:0]   avg_samples = adbm_pkg::RST_SAMPLES;
  logic [3:0]   scan_count  = adbm_pkg::RST_RANGE_COUNT;
  logic [15:0]  div_ratio   = adbm_pkg::RST_DIV_RATIO;
  logic [15:0]  low_adc     = adbm_pkg::RST_LOW_ADC;
  logic [15:0]  low_batt    = adbm_pkg::RST_LOW_BATT;
  logic [15:0]  high_adc    = adbm_pkg::RST_HIGH_ADC;
  logic [15:0]  high_batt   = adbm_pkg::RST_HIGH_BATT;
  int unsigned  chan_sum [2] = '{0, 0};
  int unsigned  chan_cnt [2] = '{0, 0};
  adbm_pkg::range_entry_t board_ranges [TABLE_DEPTH];

  adc_word_t   pending_words[$];
  reading_t    awaited_readings[$];
  adc_word_t   word_on_bus;
  int unsigned words_planned = 0;
  int unsigned words_taken   = 0;
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;

  // Knobs the stimulus process turns between phases.
  logic tx_idle_en  = 1'b1;
  logic rx_idle_en  = 1'b1;
  logic stall_armed = 1'b0;
  logic stall_done  = 1'b0;
  int   tx_gap  = 0;
  int   rx_gap  = 0;
  int   rx_hold = 0;

  // Samples per average after the zero and over-range rules are applied.
  function automatic int unsigned samples_needed();
    if (avg_samples == 0) return 1;
    if (avg_samples > SAMPLE_LIMIT) return SAMPLE_LIMIT;
    return avg_samples;
  endfunction

  // Mostly no gap, sometimes a few cycles, rarely a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Readings that tend to land on calibration points and table edges.
  function automatic logic [15:0] pick_millivolts();
    int unsigned r;
    int unsigned e;
    r = $urandom_range(0, 9);
    e = $urandom_range(0, TABLE_DEPTH - 1);
    case (r)
      0, 1, 2, 3: return 16'($urandom_range(0, 2100));
      4: return 16'(low_adc + $urandom_range(0, 40) - 20);
      5: return 16'(high_adc + $urandom_range(0, 40) - 20);
      6: return 16'(board_ranges[e].min_mv + $urandom_range(0, 2) - 1);
      7: return 16'(board_ranges[e].max_mv + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic adc_word_t make_word(logic act, logic ch, logic [15:0] mv,
                                          logic [3:0] idx, logic [15:0] lo,
                                          logic [15:0] hi, logic [7:0] ver);
    adc_word_t w;
    w.action        = act;
    w.channel       = ch;
    w.sample_mv     = mv;
    w.entry_index   = idx;
    w.entry_min_mv  = lo;
    w.entry_max_mv  = hi;
    w.entry_version = ver;
    return w;
  endfunction

  // Folds one accepted word into the shadow state and, when an average
  // completes, queues the reading the block must produce for it.
  task automatic absorb_word(input adc_word_t w);
    int unsigned     ci;
    int unsigned     limit;
    longint unsigned volts;
    longint unsigned span;
    longint unsigned dadc;
    longint unsigned dbat;
    reading_t        r;
    if (w.action == adbm_pkg::ACT_LOAD) begin
      // Indexes past the table are dropped without effect.
      if (w.entry_index < TABLE_DEPTH) begin
        board_ranges[w.entry_index].min_mv  = w.entry_min_mv;
        board_ranges[w.entry_index].max_mv  = w.entry_max_mv;
        board_ranges[w.entry_index].version = w.entry_version;
      end
      return;
    end
    ci = w.channel;
    chan_sum[ci] += w.sample_mv;
    chan_cnt[ci]++;
    // A count lowered mid-collection completes on the next sample, and the
    // mean then divides by the samples actually collected.
    if (chan_cnt[ci] < samples_needed()) return;
    r.channel    = w.channel;
    r.average_mv = 16'(chan_sum[ci] / chan_cnt[ci]);
    r.converted  = '0;
    r.matched    = 1'b1;
    chan_sum[ci] = 0;
    chan_cnt[ci] = 0;
    if (w.channel == adbm_pkg::CH_VERSION) begin
      r.matched = 1'b0;
      limit = (scan_count > TABLE_DEPTH) ? TABLE_DEPTH : scan_count;
      for (int i = 0; i < limit; i++) begin
        if (!r.matched && r.average_mv >= board_ranges[i].min_mv &&
            r.average_mv <= board_ranges[i].max_mv) begin
          r.matched   = 1'b1;
          r.converted = 24'(board_ranges[i].version);
        end
      end
    end else begin
      if (div_ratio != 0) begin
        volts = (64'(r.average_mv) * div_ratio) / adbm_pkg::RATIO_SCALE;
      end else if (low_adc != 0 && high_adc != 0) begin
        // The low point wins when the two ADC points overlap or cross.
        if (r.average_mv <= low_adc) begin
          volts = low_batt;
        end else if (r.average_mv >= high_adc) begin
          volts = high_batt;
        end else begin
          span  = high_adc - low_adc;
          dadc  = r.average_mv - low_adc;
          dbat  = (high_batt > low_batt) ? high_batt - low_batt : 0;
          volts = low_batt + (dadc * dbat) / span;
        end
      end else begin
        volts = (64'(r.average_mv) * adbm_pkg::FALLBACK_MUL) / adbm_pkg::FALLBACK_DIV;
      end
      r.converted = (volts > adbm_pkg::SAT_MAX) ? adbm_pkg::SAT_MAX : volts[23:0];
    end
    awaited_readings.push_back(r);
  endtask

  task automatic queue_word(input adc_word_t w);
    pending_words.push_back(w);
    words_planned++;
  endtask

  // Blocks until every queued word is in and every reading is out, then lets
  // the block finish whatever internal work may still be going on.
  task automatic settle();
    while (words_taken != words_planned || awaited_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input adbm_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      adbm_pkg::REG_SAMPLES:     avg_samples = val[3:0];
      adbm_pkg::REG_RANGE_COUNT: scan_count  = val[3:0];
      adbm_pkg::REG_DIV_RATIO:   div_ratio   = val;
      adbm_pkg::REG_LOW_ADC:     low_adc     = val;
      adbm_pkg::REG_LOW_BATT:    low_batt    = val;
      adbm_pkg::REG_HIGH_ADC:    high_adc    = val;
      adbm_pkg::REG_HIGH_BATT:   high_batt   = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  // Sender: presents the oldest pending word and holds it until taken. The
  // shadow model is updated at the very edge the block accepts the word.
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_word(word_on_bus);
        words_taken++;
        offer  = 1'b0;
        tx_gap = tx_idle_en ? pick_gap() : 0;
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_words.size() > 0) begin
          word_on_bus  = pending_words.pop_front();
          s_axis_tdata <= {4'b0, word_on_bus.entry_version, word_on_bus.entry_max_mv,
                           word_on_bus.entry_min_mv, word_on_bus.entry_index,
                           word_on_bus.sample_mv};
          s_axis_tuser <= {word_on_bus.channel, word_on_bus.action};
          offer = 1'b1;
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Receiver: checks each reading against the oldest one awaited, and
  // throttles tready with random stalls plus one long hold-off when armed.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    logic     ready_next;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.channel    = m_axis_tuser[0];
        got.average_mv = m_axis_tdata[15:0];
        got.converted  = m_axis_tdata[39:16];
        got.matched    = m_axis_tdata[40];
        if (awaited_readings.size() == 0) begin
          $error("unexpected result word: channel %0d, average_mv %0d",
                 got.channel, got.average_mv);
          fault_count++;
        end else begin
          want = awaited_readings.pop_front();
          check_field("result_channel", want.channel, got.channel);
          check_field("average_mv", want.average_mv, got.average_mv);
          check_field("converted_value", want.converted, got.converted);
          check_field("range_matched", want.matched, got.matched);
        end
        rx_gap = rx_idle_en ? pick_gap() : 0;
      end
      // The long hold-off starts on the first offered result of the armed
      // phase, so the block backs up while the sender keeps pushing.
      if (stall_armed && !stall_done && m_axis_tvalid) begin
        rx_hold    = LONG_HOLD;
        stall_done = 1'b1;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        ready_next = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        ready_next = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 15) == 0) begin
        rx_gap     = pick_gap();
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned made;
    int unsigned batch;
    int unsigned target;
    logic        ch;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [3:0]  idx;

    // Power-on contents of the range table.
    for (int i = 0; i < TABLE_DEPTH; i++) board_ranges[i] = '0;
    board_ranges[0] = '{version: 8'd0, max_mv: 16'd200,  min_mv: 16'd0};
    board_ranges[1] = '{version: 8'd1, max_mv: 16'd2000, min_mv: 16'd1600};
    board_ranges[2] = '{version: 8'd2, max_mv: 16'd1000, min_mv: 16'd800};
    board_ranges[3] = '{version: 8'd3, max_mv: 16'd350,  min_mv: 16'd250};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Single-sample averages over the whole table: the top table entry,
    // loads past the end of the table, the default ranges, a miss, and the
    // calibration points of the default battery curve.
    set_reg(adbm_pkg::REG_SAMPLES, 16'd1);
    set_reg(adbm_pkg::REG_RANGE_COUNT, 16'd15);
    queue_word(make_word(adbm_pkg::ACT_LOAD, adbm_pkg::CH_VERSION, 16'd0, 4'd9,
                         16'hFFFF, 16'hFFFF, 8'hFF));
    queue_word(make_word(adbm_pkg::ACT_LOAD, adbm_pkg::CH_BATTERY, 16'd0, 4'd15,
                         16'd0, 16'd0, 8'h5A));
    queue_word(make_word(adbm_pkg::ACT_LOAD, adbm_pkg::CH_VERSION, 16'd0, 4'd10,
                         16'd0, 16'hFFFF, 8'h11));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'hFFFF, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd900, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd100, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd500, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd0, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1422, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1707, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1500, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd0, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'hFFFF, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // Empty search, and the largest divider ratio on the largest reading.
    set_reg(adbm_pkg::REG_RANGE_COUNT, 16'd0);
    set_reg(adbm_pkg::REG_DIV_RATIO, 16'hFFFF);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd100, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'hFFFF, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // A zero low calibration point falls back to the fixed scale.
    set_reg(adbm_pkg::REG_DIV_RATIO, 16'd0);
    set_reg(adbm_pkg::REG_LOW_ADC, 16'd0);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'hFFFF, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // Battery points reversed: the slope is clamped flat at the low value.
    set_reg(adbm_pkg::REG_LOW_ADC, 16'd1000);
    set_reg(adbm_pkg::REG_HIGH_ADC, 16'd2000);
    set_reg(adbm_pkg::REG_LOW_BATT, 16'd9000);
    set_reg(adbm_pkg::REG_HIGH_BATT, 16'd6000);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1500, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // ADC points crossed: the low point takes precedence where both apply.
    set_reg(adbm_pkg::REG_LOW_ADC, 16'd2000);
    set_reg(adbm_pkg::REG_HIGH_ADC, 16'd1000);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd1500, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd2500, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // A zero high calibration point falls back as well.
    set_reg(adbm_pkg::REG_HIGH_ADC, 16'd0);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_BATTERY, 16'd50, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();

    // Lower the sample count below what is already collected: the next
    // sample closes the average over all five readings.
    set_reg(adbm_pkg::REG_SAMPLES, 16'd8);
    set_reg(adbm_pkg::REG_RANGE_COUNT, 16'd4);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd10, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd20, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd30, 4'd0,
                         16'd0, 16'd0, 8'd0));
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd40, 4'd0,
                         16'd0, 16'd0, 8'd0));
    settle();
    set_reg(adbm_pkg::REG_SAMPLES, 16'd2);
    queue_word(make_word(adbm_pkg::ACT_SAMPLE, adbm_pkg::CH_VERSION, 16'd50, 4'd0,
                         16'd0, 16'd0, 8'd0));

    // Random phases. Each one starts from an idle block with fresh register
    // values; the first few pin the extremes. Most of the traffic is whole
    // batches of samples on one channel around a chosen level, the rest is
    // table loads, stray samples and batches of the wrong length.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      tx_idle_en  = (p % 3 != 1);
      rx_idle_en  = (p % 4 != 2);
      stall_armed = (p == 0);
      set_reg(adbm_pkg::REG_SAMPLES, {12'($urandom),
                                      (p == 0) ? 4'd0 : (p == 1) ? 4'd15 :
                                      4'($urandom_range(1, 6))});
      set_reg(adbm_pkg::REG_RANGE_COUNT, {12'($urandom),
                                          (p == 2) ? 4'd0 : (p == 1) ? 4'd15 :
                                          4'($urandom_range(0, 15))});
      set_reg(adbm_pkg::REG_DIV_RATIO, (p == 1) ? 16'hFFFF :
                                       ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                                       16'd0);
      lo = 16'($urandom_range(500, 2000));
      hi = 16'(lo + $urandom_range(1, 1000));
      if ($urandom_range(0, 4) == 0) hi = 16'($urandom);
      if ($urandom_range(0, 5) == 0) lo = 16'd0;
      if (p == 2) begin
        lo = 16'hFFFF;
        hi = 16'hFFFF;
      end
      if (p == 3) hi = 16'd0;
      set_reg(adbm_pkg::REG_LOW_ADC, lo);
      set_reg(adbm_pkg::REG_HIGH_ADC, hi);
      set_reg(adbm_pkg::REG_LOW_BATT, (p == 4) ? 16'hFFFF : (p == 5) ? 16'd0 :
                                      16'($urandom_range(5000, 9000)));
      set_reg(adbm_pkg::REG_HIGH_BATT, (p == 4) ? 16'hFFFF : (p == 5) ? 16'd0 :
                                       ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                       16'($urandom_range(7000, 12000)));
      made = 0;
      while (made < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          batch = samples_needed();
          if ($urandom_range(0, 9) == 0) batch = $urandom_range(1, SAMPLE_LIMIT);
          ch     = 1'($urandom_range(0, 1));
          target = pick_millivolts();
          repeat (batch) begin
            queue_word(make_word(adbm_pkg::ACT_SAMPLE, ch,
                                 ($urandom_range(0, 1) == 0) ? 16'(target) :
                                 16'(target + $urandom_range(0, 6) - 3),
                                 4'($urandom), 16'($urandom), 16'($urandom),
                                 8'($urandom)));
            made++;
          end
        end else if ($urandom_range(0, 1) == 0) begin
          idx = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, TABLE_DEPTH - 1)) :
                                               4'($urandom_range(TABLE_DEPTH, 15));
          lo  = 16'($urandom_range(0, 3000));
          hi  = 16'(lo + $urandom_range(0, 400));
          if ($urandom_range(0, 4) == 0) begin
            lo = 16'($urandom);
            hi = 16'($urandom);
          end
          queue_word(make_word(adbm_pkg::ACT_LOAD, 1'($urandom), 16'($urandom), idx,
                               lo, hi, 8'($urandom)));
          made++;
        end else begin
          queue_word(make_word(adbm_pkg::ACT_SAMPLE, 1'($urandom), 16'($urandom),
                               4'($urandom), 16'($urandom), 16'($urandom),
                               8'($urandom)));
          made++;
        end
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/adbm_pkg.sv
src/adbm_div.sv
src/adbm_datapath.sv
src/adbm_ctrl.sv
src/adc_board_id_and_battery_monitor.sv
src/adbm_checker.sv
tb/testbench.sv
